@@ rtl/lbvh_pkg.sv @@
package lbvh_pkg;

    localparam int CODE_W     = 32;
    localparam int IDX_W      = 10;
    localparam int CNT_W      = 11;
    localparam int CHILD_W    = 11;
    localparam int STAT_W     = 2;
    localparam int LZ_W       = 6;
    localparam int CFG_ADDR_W = 3;
    localparam int APB_W      = 32;

    typedef logic signed [7:0] delta_t;

    localparam delta_t DELTA_NONE    = -8'sd1;
    localparam delta_t DELTA_EQ_BIAS = 8'sd32;

    localparam logic [0:0] ACT_WRITE = 1'b0;
    localparam logic [0:0] ACT_QUERY = 1'b1;

    localparam logic [STAT_W-1:0] ST_WRITTEN = 2'd0;
    localparam logic [STAT_W-1:0] ST_NODE    = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE   = 2'd2;

    localparam logic [CFG_ADDR_W-3:0] REG_OBJECT_COUNT = '0;

    function automatic logic [LZ_W-1:0] clz32(input logic [CODE_W-1:0] x);
        logic [CODE_W-1:0] v;
        logic [LZ_W-1:0]   c;
        v = x;
        c = '0;
        if (v[31:16] == 16'd0)
        begin
            c = c + 6'd16;
            v = v << 16;
        end
        if (v[31:24] == 8'd0)
        begin
            c = c + 6'd8;
            v = v << 8;
        end
        if (v[31:28] == 4'd0)
        begin
            c = c + 6'd4;
            v = v << 4;
        end
        if (v[31:30] == 2'd0)
        begin
            c = c + 6'd2;
            v = v << 2;
        end
        if (v[31] == 1'b0)
        begin
            c = c + 6'd1;
            v = v << 1;
        end
        if (v[31] == 1'b0)
        begin
            c = c + 6'd1;
        end
        return c;
    endfunction

endpackage

@@ rtl/lbvh_ram.sv @@
module lbvh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/lbvh_cfg.sv @@
module lbvh_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lbvh_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [lbvh_pkg::APB_W-1:0]      pwdata,
    output logic [lbvh_pkg::APB_W-1:0]      prdata,
    output logic                           pready,
    output logic [lbvh_pkg::CNT_W-1:0]      object_count
);

    import lbvh_pkg::*;

    logic             reg_sel;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign reg_sel = (paddr[CFG_ADDR_W-1:2] == REG_OBJECT_COUNT);
    assign pready  = 1'b1;

    always_comb
    begin
        count_next = count_reg;
        if (psel && penable && pwrite && reg_sel)
        begin
            count_next = pwdata[CNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign prdata       = reg_sel ? APB_W'(count_reg) : '0;
    assign object_count = count_reg;

endmodule

@@ rtl/lbvh_internal_node_build.sv @@
// A write goes from S_IDLE to S_DONE, which then registers the response.
// A query reads the index code and its two neighbours, then runs expansion probes, search
// probes, the end probe and split probes, one request at a time.
// Each probe reads the single read port of the code store and waits for its registered data.
// Reset clears the object count and the control state; the code store holds no reset value.
module lbvh_internal_node_build #(
    parameter int MAX_OBJECTS = 1024
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [lbvh_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [lbvh_pkg::APB_W-1:0]      pwdata,
    output logic [lbvh_pkg::APB_W-1:0]      prdata,
    output logic                            pready,
    input  logic                            req_valid,
    output logic                            req_stall,
    input  logic                            action,
    input  logic [lbvh_pkg::IDX_W-1:0]      index,
    input  logic [lbvh_pkg::CODE_W-1:0]     morton_code,
    output logic                            rsp_valid,
    input  logic                            rsp_stall,
    output logic [lbvh_pkg::STAT_W-1:0]     status,
    output logic [lbvh_pkg::IDX_W-1:0]      range_first,
    output logic [lbvh_pkg::IDX_W-1:0]      range_last,
    output logic [lbvh_pkg::IDX_W-1:0]      split_position,
    output logic [lbvh_pkg::CHILD_W-1:0]    left_node,
    output logic [lbvh_pkg::CHILD_W-1:0]    right_node,
    output logic                            left_is_leaf,
    output logic                            right_is_leaf
);

    import lbvh_pkg::*;

    localparam int AW    = $clog2(MAX_OBJECTS);
    localparam int POS_W = ((AW > CNT_W) ? AW : CNT_W) + 3;

    typedef logic signed [POS_W-1:0] pos_t;

    localparam pos_t MAX_P = pos_t'(MAX_OBJECTS);
    localparam pos_t ONE_P = pos_t'(1);
    localparam pos_t TWO_P = pos_t'(2);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CODEI = 4'd1;
    localparam logic [3:0] S_NEXT  = 4'd2;
    localparam logic [3:0] S_PREV  = 4'd3;
    localparam logic [3:0] S_EXP   = 4'd4;
    localparam logic [3:0] S_BIN   = 4'd5;
    localparam logic [3:0] S_ENDS  = 4'd6;
    localparam logic [3:0] S_SPLC  = 4'd7;
    localparam logic [3:0] S_SPL   = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;

    function automatic pos_t step_from(input pos_t base, input pos_t off, input logic neg);
        return neg ? (base - off) : (base + off);
    endfunction

    logic [CNT_W-1:0]  object_count;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [AW-1:0]     ram_raddr;
    logic [CODE_W-1:0] ram_rdata;

    logic [3:0]        state_reg, state_next;
    logic              rd_pend_reg, rd_pend_next;
    pos_t              probe_reg, probe_next;
    pos_t              i_reg, i_next;
    pos_t              n_reg, n_next;
    logic [CODE_W-1:0] code_i_reg, code_i_next;
    logic [CODE_W-1:0] fcode_reg, fcode_next;
    delta_t            dpos_reg, dpos_next;
    delta_t            dmin_reg, dmin_next;
    logic              dir_neg_reg, dir_neg_next;
    pos_t              lmax_reg, lmax_next;
    pos_t              len_reg, len_next;
    pos_t              t_reg, t_next;
    pos_t              first_reg, first_next;
    pos_t              last_reg, last_next;
    pos_t              split_reg, split_next;
    pos_t              step_reg, step_next;
    logic [LZ_W-1:0]   common_reg, common_next;
    logic [STAT_W-1:0] res_status_reg, res_status_next;

    logic               rsp_valid_reg, rsp_valid_next;
    logic [STAT_W-1:0]  status_reg, status_next;
    logic [IDX_W-1:0]   range_first_reg, range_first_next;
    logic [IDX_W-1:0]   range_last_reg, range_last_next;
    logic [IDX_W-1:0]   split_position_reg, split_position_next;
    logic [CHILD_W-1:0] left_node_reg, left_node_next;
    logic [CHILD_W-1:0] right_node_reg, right_node_next;
    logic               left_is_leaf_reg, left_is_leaf_next;
    logic               right_is_leaf_reg, right_is_leaf_next;

    pos_t              idx_pos;
    pos_t              cnt_pos;
    pos_t              count_n;
    logic              probe_in;
    logic              codes_eq;
    pos_t              pos_xor;
    logic [CODE_W-1:0] x_word;
    logic [LZ_W-1:0]   lz;
    delta_t            delta_raw;
    delta_t            delta;
    logic              delta_gt;
    logic [LZ_W-1:0]   split_lz;
    logic              split_hit;
    pos_t              len_upd;
    pos_t              t_half;
    pos_t              j_pos;
    pos_t              step_half;
    logic              lleaf;
    logic              rleaf;
    pos_t              lchild;
    pos_t              rchild;

    lbvh_cfg u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .object_count (object_count)
    );

    lbvh_ram #(
        .WIDTH (CODE_W),
        .DEPTH (MAX_OBJECTS)
    ) u_code_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (morton_code),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign idx_pos   = $signed({{(POS_W-IDX_W){1'b0}}, index});
    assign cnt_pos   = $signed({{(POS_W-CNT_W){1'b0}}, object_count});
    assign count_n   = (cnt_pos > MAX_P) ? MAX_P : cnt_pos;
    assign ram_waddr = idx_pos[AW-1:0];
    assign ram_raddr = probe_reg[AW-1:0];

    assign probe_in  = (probe_reg >= pos_t'(0)) && (probe_reg < n_reg);
    assign codes_eq  = (code_i_reg == ram_rdata);
    assign pos_xor   = i_reg ^ probe_reg;
    assign x_word    = codes_eq ? CODE_W'($unsigned(pos_xor)) : (code_i_reg ^ ram_rdata);
    assign lz        = clz32(x_word);
    assign delta_raw = codes_eq ? (DELTA_EQ_BIAS + delta_t'(lz)) : delta_t'(lz);
    assign delta     = probe_in ? delta_raw : DELTA_NONE;
    assign delta_gt  = (delta > dmin_reg);

    assign split_lz  = clz32(fcode_reg ^ ram_rdata);
    assign split_hit = (probe_reg < last_reg) && (split_lz > common_reg);

    assign len_upd   = delta_gt ? (len_reg + t_reg) : len_reg;
    assign t_half    = t_reg >>> 1;
    assign j_pos     = step_from(i_reg, len_upd, dir_neg_reg);
    assign step_half = (step_reg + ONE_P) >>> 1;

    assign lleaf  = (split_reg == first_reg);
    assign rleaf  = ((split_reg + ONE_P) == last_reg);
    assign lchild = lleaf ? (n_reg - ONE_P + split_reg) : split_reg;
    assign rchild = rleaf ? (n_reg + split_reg) : (split_reg + ONE_P);

    assign req_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next          = state_reg;
        rd_pend_next        = rd_pend_reg;
        probe_next          = probe_reg;
        i_next              = i_reg;
        n_next              = n_reg;
        code_i_next         = code_i_reg;
        fcode_next          = fcode_reg;
        dpos_next           = dpos_reg;
        dmin_next           = dmin_reg;
        dir_neg_next        = dir_neg_reg;
        lmax_next           = lmax_reg;
        len_next            = len_reg;
        t_next              = t_reg;
        first_next          = first_reg;
        last_next           = last_reg;
        split_next          = split_reg;
        step_next           = step_reg;
        common_next         = common_reg;
        res_status_next     = res_status_reg;
        ram_we              = 1'b0;

        rsp_valid_next      = rsp_valid_reg;
        status_next         = status_reg;
        range_first_next    = range_first_reg;
        range_last_next     = range_last_reg;
        split_position_next = split_position_reg;
        left_node_next      = left_node_reg;
        right_node_next     = right_node_reg;
        left_is_leaf_next   = left_is_leaf_reg;
        right_is_leaf_next  = right_is_leaf_reg;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    if (action == ACT_WRITE)
                    begin
                        if (idx_pos < MAX_P)
                        begin
                            ram_we          = 1'b1;
                            res_status_next = ST_WRITTEN;
                        end
                        else
                        begin
                            res_status_next = ST_RANGE;
                        end
                        state_next = S_DONE;
                    end
                    else
                    begin
                        n_next       = count_n;
                        i_next       = idx_pos;
                        probe_next   = idx_pos;
                        rd_pend_next = 1'b0;
                        if ((count_n < TWO_P) || (idx_pos >= (count_n - ONE_P)))
                        begin
                            res_status_next = ST_RANGE;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            state_next = S_CODEI;
                        end
                    end
                end
            end

            S_CODEI:
            begin
                if (!rd_pend_reg)
                begin
                    rd_pend_next = 1'b1;
                end
                else
                begin
                    rd_pend_next = 1'b0;
                    code_i_next  = ram_rdata;
                    probe_next   = i_reg + ONE_P;
                    state_next   = S_NEXT;
                end
            end

            S_NEXT:
            begin
                if (!rd_pend_reg)
                begin
                    rd_pend_next = 1'b1;
                end
                else
                begin
                    rd_pend_next = 1'b0;
                    dpos_next    = delta;
                    probe_next   = i_reg - ONE_P;
                    state_next   = S_PREV;
                end
            end

            S_PREV:
            begin
                if (!rd_pend_reg)
                begin
                    rd_pend_next = 1'b1;
                end
                else
                begin
                    rd_pend_next = 1'b0;
                    dir_neg_next = !(dpos_reg >= delta);
                    dmin_next    = (dpos_reg >= delta) ? delta : dpos_reg;
                    lmax_next    = TWO_P;
                    probe_next   = step_from(i_reg, TWO_P, !(dpos_reg >= delta));
                    state_next   = S_EXP;
                end
            end

            S_EXP:
            begin
                if (!rd_pend_reg)
                begin
                    rd_pend_next = 1'b1;
                end
                else
                begin
                    rd_pend_next = 1'b0;
                    if (delta_gt)
                    begin
                        lmax_next  = lmax_reg <<< 1;
                        probe_next = step_from(i_reg, lmax_reg <<< 1, dir_neg_reg);
                    end
                    else
                    begin
                        t_next     = lmax_reg >>> 1;
                        len_next   = '0;
                        probe_next = step_from(i_reg, lmax_reg >>> 1, dir_neg_reg);
                        state_next = S_BIN;
                    end
                end
            end

            S_BIN:
            begin
                if (!rd_pend_reg)
                begin
                    rd_pend_next = 1'b1;
                end
                else
                begin
                    rd_pend_next = 1'b0;
                    len_next     = len_upd;
                    if (t_reg == ONE_P)
                    begin
                        first_next = dir_neg_reg ? j_pos : i_reg;
                        last_next  = dir_neg_reg ? i_reg : j_pos;
                        probe_next = j_pos;
                        state_next = S_ENDS;
                    end
                    else
                    begin
                        t_next     = t_half;
                        probe_next = step_from(i_reg, len_upd + t_half, dir_neg_reg);
                    end
                end
            end

            S_ENDS:
            begin
                if (!rd_pend_reg)
                begin
                    rd_pend_next = 1'b1;
                end
                else
                begin
                    rd_pend_next = 1'b0;
                    fcode_next   = dir_neg_reg ? ram_rdata : code_i_reg;
                    if (codes_eq)
                    begin
                        split_next      = (first_reg + last_reg) >>> 1;
                        res_status_next = ST_NODE;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        common_next = lz;
                        split_next  = first_reg;
                        step_next   = last_reg - first_reg;
                        state_next  = S_SPLC;
                    end
                end
            end

            S_SPLC:
            begin
                step_next    = step_half;
                probe_next   = split_reg + step_half;
                rd_pend_next = 1'b0;
                state_next   = S_SPL;
            end

            S_SPL:
            begin
                if (!rd_pend_reg)
                begin
                    rd_pend_next = 1'b1;
                end
                else
                begin
                    rd_pend_next = 1'b0;
                    if (split_hit)
                    begin
                        split_next = probe_reg;
                    end
                    if (step_reg > ONE_P)
                    begin
                        state_next = S_SPLC;
                    end
                    else
                    begin
                        res_status_next = ST_NODE;
                        state_next      = S_DONE;
                    end
                end
            end

            S_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next = 1'b1;
                    status_next    = res_status_reg;
                    if (res_status_reg == ST_NODE)
                    begin
                        range_first_next    = first_reg[IDX_W-1:0];
                        range_last_next     = last_reg[IDX_W-1:0];
                        split_position_next = split_reg[IDX_W-1:0];
                        left_node_next      = lchild[CHILD_W-1:0];
                        right_node_next     = rchild[CHILD_W-1:0];
                        left_is_leaf_next   = lleaf;
                        right_is_leaf_next  = rleaf;
                    end
                    else
                    begin
                        range_first_next    = '0;
                        range_last_next     = '0;
                        split_position_next = '0;
                        left_node_next      = '0;
                        right_node_next     = '0;
                        left_is_leaf_next   = 1'b0;
                        right_is_leaf_next  = 1'b0;
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rd_pend_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_pend_reg   <= rd_pend_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        probe_reg          <= probe_next;
        i_reg              <= i_next;
        n_reg              <= n_next;
        code_i_reg         <= code_i_next;
        fcode_reg          <= fcode_next;
        dpos_reg           <= dpos_next;
        dmin_reg           <= dmin_next;
        dir_neg_reg        <= dir_neg_next;
        lmax_reg           <= lmax_next;
        len_reg            <= len_next;
        t_reg              <= t_next;
        first_reg          <= first_next;
        last_reg           <= last_next;
        split_reg          <= split_next;
        step_reg           <= step_next;
        common_reg         <= common_next;
        res_status_reg     <= res_status_next;
        status_reg         <= status_next;
        range_first_reg    <= range_first_next;
        range_last_reg     <= range_last_next;
        split_position_reg <= split_position_next;
        left_node_reg      <= left_node_next;
        right_node_reg     <= right_node_next;
        left_is_leaf_reg   <= left_is_leaf_next;
        right_is_leaf_reg  <= right_is_leaf_next;
    end

    assign rsp_valid      = rsp_valid_reg;
    assign status         = status_reg;
    assign range_first    = range_first_reg;
    assign range_last     = range_last_reg;
    assign split_position = split_position_reg;
    assign left_node      = left_node_reg;
    assign right_node     = right_node_reg;
    assign left_is_leaf   = left_is_leaf_reg;
    assign right_is_leaf  = right_is_leaf_reg;

endmodule
